/* rtl/pmrb_pkg.sv */
// Shared types and codes for the processing element register block.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package pmrb_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;

    // bus action codes
    localparam logic [1:0] ACT_IDLE  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // register selects
    localparam logic [4:0] SEL_MEMORY   = 5'd0;
    localparam logic [4:0] SEL_MASK     = 5'd1;
    localparam logic [4:0] SEL_STATUS   = 5'd2;
    localparam logic [4:0] SEL_SLICE    = 5'd3;
    localparam logic [4:0] SEL_NODE     = 5'd4;
    localparam logic [4:0] SEL_TICKS    = 5'd5;
    localparam logic [4:0] SEL_SEND_BSY = 5'd6;
    localparam logic [4:0] SEL_RECV_BSY = 5'd7;
    localparam logic [4:0] SEL_PERIPH   = 5'd8;
    localparam logic [4:0] SEL_PENDING  = 5'd9;
    localparam logic [4:0] SEL_SLACK    = 5'd10;
    localparam logic [4:0] SEL_HOLD     = 5'd11;
    localparam logic [4:0] SEL_END      = 5'd12;
    localparam logic [4:0] SEL_DMA_LO   = 5'd13;
    localparam logic [4:0] SEL_DMA_HI   = 5'd18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLACK_WINDOW = 2'd1;

    localparam logic [DATA_W-1:0] SLACK_WINDOW_RESET = 32'd1000000;

    // interrupt status bit positions
    localparam int ST_PENDING = 0;
    localparam int ST_SLACK   = 1;
    localparam int ST_SLICE   = 3;
    localparam int ST_NI      = 5;

    typedef struct packed {
        logic [1:0]        action;
        logic [4:0]        reg_select;
        logic [DATA_W-1:0] write_data;
        logic              ni_interrupt;
        logic              dma_send_busy;
        logic              dma_receive_busy;
        logic [DATA_W-1:0] memory_read_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [7:0]        interrupt_status;
        logic              interrupt_line;
        logic [2:0]        dma_command;
        logic              end_strobe;
        logic              clock_enabled;
    } out_item_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
    } cfg_write_t;

endpackage

`default_nettype wire

/* rtl/pe_mapped_register_block.sv */
// Top level of the processing element register block.
// Depends on pmrb_pkg, pmrb_in_stage and pmrb_core.
//
// Usage:
//   in_valid/in_ready/in_data carry one request per bus tick: an idle tick,
//   a register read or a register write. Every accepted request advances
//   the tick counter by one step; unless written, the slice countdown steps
//   down to 1 and the slack timer up to the slack window.
//   out_valid/out_ready/out_data return exactly one result per request:
//   read word, interrupt status and line, DMA command, end strobe, clock
//   enable.
//   cfg_we/cfg_index/cfg_data write node address (0) and slack window (1);
//   write them only while no request is in flight.
//   A request passes the input register, then the result register.
//   Throughput: one request per cycle while out_ready is high, set by the
//   single state update between the two registers.
//   Stall: while out_ready is low the result register holds; one more
//   request may sit in the input register, then in_ready drops.
//   Reset: both registers empty, state at its reset values, clock enabled,
//   slack window 1000000.
`default_nettype none

module pe_mapped_register_block (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire pmrb_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output pmrb_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_we,
    input  wire logic [pmrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pmrb_pkg::DATA_W-1:0]       cfg_data
);

    logic                 stage_valid;
    pmrb_pkg::in_item_t   stage_data;
    logic                 advance;
    logic                 fire;
    pmrb_pkg::out_item_t  result;
    pmrb_pkg::cfg_write_t cfg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pmrb_pkg::out_item_t  out_data_reg;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = stage_valid && advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    pmrb_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    pmrb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (stage_data),
        .result (result)
    );

    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // input side only backs up when both registers are full and stalled
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    a_strobe_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.end_strobe && out_data.dma_command != 3'd0))
        else $error("end strobe and dma command together");

    a_line_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.interrupt_line) |-> (out_data.interrupt_status != 8'h00))
        else $error("interrupt line without status");

    a_status_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.interrupt_status & 8'hD4) == 8'h00))
        else $error("reserved status bits set");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("request lost between stages");

endmodule

`default_nettype wire

/* rtl/pmrb_in_stage.sv */
// Input register stage of the register block: holds one request.
// Depends on pmrb_pkg.
`default_nettype none

module pmrb_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pmrb_pkg::in_item_t in_data,
    input  wire logic               advance,
    output logic                    stage_valid,
    output pmrb_pkg::in_item_t      stage_data
);

    logic               valid_reg;
    logic               valid_next;
    pmrb_pkg::in_item_t data_reg;

    assign in_ready    = !valid_reg || advance;
    assign valid_next  = (in_valid && in_ready) || (valid_reg && !advance);
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/pmrb_core.sv */
// Register file, counters and read mux of the register block.
// Depends on pmrb_pkg. Result is combinational from the staged request.
`default_nettype none

module pmrb_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pmrb_pkg::cfg_write_t cfg,
    input  wire logic                 fire,
    input  wire pmrb_pkg::in_item_t   item,
    output pmrb_pkg::out_item_t       result
);

    localparam int W = pmrb_pkg::DATA_W;

    logic [15:0]  node_address_reg;
    logic [W-1:0] slack_window_reg;
    logic [7:0]   int_mask_reg,    int_mask_next;
    logic [W-1:0] slice_count_reg, slice_count_next;
    logic [W-1:0] tick_count_reg,  tick_count_next;
    logic         pending_reg,     pending_next;
    logic [W-1:0] slack_count_reg, slack_count_next;
    logic [W-1:0] periph_reg,      periph_next;
    logic         clock_on_reg,    clock_on_next;

    logic         wr;
    logic [7:0]   status;
    logic [W-1:0] rd;
    logic [4:0]   cmd_diff;
    logic         slice_one;
    logic         wake;

    always_comb
    begin
        wr        = (item.action == pmrb_pkg::ACT_WRITE);
        slice_one = (slice_count_reg == W'(1));

        status = 8'h00;
        status[pmrb_pkg::ST_NI]      = item.ni_interrupt;
        status[pmrb_pkg::ST_SLICE]   = slice_one;
        status[pmrb_pkg::ST_SLACK]   = !item.dma_send_busy
                                       && (slack_count_reg == slack_window_reg);
        status[pmrb_pkg::ST_PENDING] = !item.dma_send_busy && pending_reg;

        unique case (item.reg_select)
            pmrb_pkg::SEL_MASK:     rd = {{(W-8){1'b0}}, int_mask_reg};
            pmrb_pkg::SEL_STATUS:   rd = {{(W-8){1'b0}}, status};
            pmrb_pkg::SEL_SLICE:    rd = slice_count_reg;
            pmrb_pkg::SEL_NODE:     rd = {{(W-16){1'b0}}, node_address_reg};
            pmrb_pkg::SEL_TICKS:    rd = tick_count_reg;
            pmrb_pkg::SEL_SEND_BSY: rd = {{(W-1){1'b0}}, item.dma_send_busy};
            pmrb_pkg::SEL_RECV_BSY: rd = {{(W-1){1'b0}}, item.dma_receive_busy};
            pmrb_pkg::SEL_PERIPH:   rd = periph_reg;
            default:                rd = item.memory_read_data;
        endcase

        cmd_diff = item.reg_select - pmrb_pkg::SEL_END;

        // hold decision works on the state before this tick
        wake = item.ni_interrupt || slice_one || status[pmrb_pkg::ST_SLACK];
        if (wr && item.reg_select == pmrb_pkg::SEL_HOLD)
            clock_on_next = 1'b0;
        else if (wake)
            clock_on_next = 1'b1;
        else
            clock_on_next = clock_on_reg;

        int_mask_next = (wr && item.reg_select == pmrb_pkg::SEL_MASK)
                        ? item.write_data[7:0] : int_mask_reg;

        if (wr && item.reg_select == pmrb_pkg::SEL_SLICE)
            slice_count_next = item.write_data;
        else if (slice_count_reg > W'(1))
            slice_count_next = slice_count_reg - W'(1);
        else
            slice_count_next = slice_count_reg;

        pending_next = (wr && item.reg_select == pmrb_pkg::SEL_PENDING)
                       ? (item.write_data != '0) : pending_reg;

        if (wr && item.reg_select == pmrb_pkg::SEL_SLACK)
            slack_count_next = item.write_data;
        else if (slack_count_reg < slack_window_reg)
            slack_count_next = slack_count_reg + W'(1);
        else
            slack_count_next = slack_count_reg;

        periph_next = (wr && item.reg_select == pmrb_pkg::SEL_PERIPH)
                      ? item.write_data : periph_reg;

        tick_count_next = tick_count_reg + W'(1);

        result.read_data        = rd;
        result.interrupt_status = status;
        result.interrupt_line   = |(status & int_mask_reg);
        result.dma_command      = (wr && item.reg_select >= pmrb_pkg::SEL_DMA_LO
                                   && item.reg_select <= pmrb_pkg::SEL_DMA_HI)
                                  ? cmd_diff[2:0] : 3'd0;
        result.end_strobe       = wr && (item.reg_select == pmrb_pkg::SEL_END);
        result.clock_enabled    = clock_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= '0;
            slack_window_reg <= pmrb_pkg::SLACK_WINDOW_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                pmrb_pkg::CFG_NODE_ADDRESS: node_address_reg <= cfg.data[15:0];
                pmrb_pkg::CFG_SLACK_WINDOW: slack_window_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_mask_reg    <= '0;
            slice_count_reg <= '0;
            tick_count_reg  <= '0;
            pending_reg     <= 1'b0;
            slack_count_reg <= '0;
            periph_reg      <= '0;
            clock_on_reg    <= 1'b1;
        end
        else if (fire)
        begin
            int_mask_reg    <= int_mask_next;
            slice_count_reg <= slice_count_next;
            tick_count_reg  <= tick_count_next;
            pending_reg     <= pending_next;
            slack_count_reg <= slack_count_next;
            periph_reg      <= periph_next;
            clock_on_reg    <= clock_on_next;
        end
    end

endmodule

`default_nettype wire
